>>> rtl/cmt_pkg.sv
// ============================================================================
// cmt_pkg
// Shared constants, types and the quarter-wave sine table of the chorus unit.
// ============================================================================
package cmt_pkg;

  // History store geometry. The store length is a power of two, so wrapping
  // a read or write position is a plain truncation to HIST_AW bits.
  localparam int HIST_AW     = 16;
  localparam int HISTORY_LEN = 1 << HIST_AW;

  // Tap count limits.
  localparam int MAX_TAPS = 4;
  localparam int TAP_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int COUNT_W  = 3;

  // Field widths.
  localparam int SAMPLE_W = 16;
  localparam int HIST_W   = 2 * SAMPLE_W;
  localparam int DELAY_W  = 16;
  localparam int DEPTH_W  = 12;
  localparam int STEP_W   = 16;
  localparam int GAIN_W   = 9;
  localparam int PHASE_W  = 16;
  localparam int SINE_W   = 15;

  // Datapath widths.
  localparam int MAG_W  = DEPTH_W + SINE_W;
  localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
  localparam int ACC_W  = PROD_W + 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 62;

  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = CFG_IDX_W'(0);
  localparam int                   REG_TAP_FIRST = 1;

  // One tap's settings, laid out as in its configuration register.
  typedef struct packed {
    logic [GAIN_W-1:0]  gain_r;
    logic [GAIN_W-1:0]  gain_l;
    logic [STEP_W-1:0]  step;
    logic [DEPTH_W-1:0] depth;
    logic [DELAY_W-1:0] delay;
  } tap_cfg_t;

  localparam int TAP_CFG_W = $bits(tap_cfg_t);

  // Sequencer to tap path.
  typedef struct packed {
    logic             clear;
    logic             issue;
    logic [TAP_W-1:0] tap;
  } tap_ctrl_t;

  // Tap path to sequencer.
  typedef struct packed {
    logic                    busy;
    logic signed [ACC_W-1:0] acc_l;
    logic signed [ACC_W-1:0] acc_r;
  } tap_stat_t;

  // Quarter-wave sine table, Q0.15 magnitudes.
  localparam int          SINE_TABLE_LEN = 256;
  localparam int          SINE_IDX_W     = $clog2(SINE_TABLE_LEN + 1);
  localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;

  typedef logic [SINE_W-1:0] sine_tbl_t [SINE_TABLE_LEN+1];

  // Builds the table at elaboration with a nine-term Taylor series in Q2.30.
  function automatic sine_tbl_t build_sine();
    sine_tbl_t   tbl;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] q;
    for (int i = 0; i <= SINE_TABLE_LEN; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_LEN;
      term = x;
      sum  = x;
      for (int k = 1; k <= 8; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'((2 * k) * (2 * k + 1));
        if (k[0]) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      q = (sum + 64'd16384) >> 15;
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      tbl[i] = q[SINE_W-1:0];
    end
    return tbl;
  endfunction

  localparam sine_tbl_t SINE_TBL = build_sine();

  // Sine magnitude of a phase; the sign is the phase's top bit.
  function automatic logic [SINE_W-1:0] sine_mag(input logic [PHASE_W-1:0] ph);
    logic [31:0]           kp;
    logic [SINE_IDX_W-1:0] k;
    logic [SINE_IDX_W-1:0] idx;
    kp  = (32'(ph[PHASE_W-3:0]) * 32'(SINE_TABLE_LEN)) >> (PHASE_W - 2);
    k   = kp[SINE_IDX_W-1:0];
    idx = ph[PHASE_W-2] ? SINE_IDX_W'(SINE_TABLE_LEN) - k : k;
    return SINE_TBL[idx];
  endfunction

endpackage

>>> rtl/cmt_if.sv
// ============================================================================
// cmt_if
// Valid/ready channel interfaces: sample input, result output, configuration.
// ============================================================================

// Input samples.
interface cmt_in_if import cmt_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_left;
  logic signed [SAMPLE_W-1:0] sample_right;

  modport source (output valid, sample_left, sample_right, input ready);
  modport sink   (input valid, sample_left, sample_right, output ready);
endinterface

// Chorus results.
interface cmt_out_if import cmt_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_left;
  logic signed [SAMPLE_W-1:0] out_right;

  modport source (output valid, out_left, out_right, input ready);
  modport sink   (input valid, out_left, out_right, output ready);
endinterface

// Register writes.
interface cmt_cfg_if import cmt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

>>> rtl/cmt_ram.sv
// ============================================================================
// cmt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module cmt_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 4,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/cmt_cfg.sv
// ============================================================================
// cmt_cfg
// Configuration registers: tap count and the packed settings of each tap.
// ============================================================================
module cmt_cfg import cmt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  cmt_cfg_if.sink            cfg_i,
  output logic [COUNT_W-1:0] active_o,
  output tap_cfg_t           tap_cfg_o [MAX_TAPS]
);

  logic [COUNT_W-1:0] count_q;
  tap_cfg_t           tap_q [MAX_TAPS];

  // Writes are always taken; indexes past the list are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int t = 0; t < MAX_TAPS; t++) begin
        tap_q[t] <= '0;
      end
    end else if (cfg_i.valid) begin
      if (cfg_i.idx == REG_TAP_COUNT) begin
        count_q <= cfg_i.data[COUNT_W-1:0];
      end
      for (int t = 0; t < MAX_TAPS; t++) begin
        if (cfg_i.idx == CFG_IDX_W'(REG_TAP_FIRST + t)) begin
          tap_q[t] <= tap_cfg_t'(cfg_i.data[TAP_CFG_W-1:0]);
        end
      end
    end
  end

  // A count above the tap limit runs all taps.
  assign active_o = (count_q > COUNT_W'(MAX_TAPS)) ? COUNT_W'(MAX_TAPS) : count_q;

  always_comb begin
    for (int t = 0; t < MAX_TAPS; t++) begin
      tap_cfg_o[t] = tap_q[t];
    end
  end

endmodule

>>> rtl/cmt_tap_path.sv
// ============================================================================
// cmt_tap_path
// Per-tap pipeline: LFO phase memory, sine lookup, read address, gain and sum.
// ============================================================================
module cmt_tap_path import cmt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tap_ctrl_t          ctrl_i,
  input  tap_cfg_t           tap_cfg_i [MAX_TAPS],
  input  logic [HIST_AW-1:0] wp_i,
  input  logic               hist_full_i,
  output logic [HIST_AW-1:0] hist_raddr_o,
  input  logic [HIST_W-1:0]  hist_rdata_i,
  output tap_stat_t          stat_o
);

  // Stage valid bits and tap numbers.
  logic             s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q;
  logic [TAP_W-1:0] s1_tap_q, s2_tap_q, s3_tap_q, s4_tap_q;

  // Stage payloads.
  logic [SINE_W-1:0]        s2_mag_q;
  logic                     s2_neg_q;
  logic [MAG_W-1:0]         s3_prod_q;
  logic                     s3_neg_q;
  logic                     s4_hv_q;
  logic signed [PROD_W-1:0] s5_pl_q, s5_pr_q;
  logic signed [ACC_W-1:0]  acc_l_q, acc_r_q;

  // Phase store: reads as zero after reset, tracked with one valid bit per tap.
  logic [MAX_TAPS-1:0] ph_vld_q;
  logic [PHASE_W-1:0]  ph_rdata;
  logic [PHASE_W-1:0]  phase;
  logic [PHASE_W-1:0]  phase_next;

  // Read-address and history data path.
  logic [MAG_W:0]           rnd;
  logic [DEPTH_W-1:0]       off;
  logic [HIST_AW-1:0]       off_w;
  logic [HIST_AW-1:0]       pos;
  logic                     pos_vld;
  logic [HIST_W-1:0]        word;
  logic signed [PROD_W-1:0] hl_x, hr_x, gl_x, gr_x;

  cmt_ram #(
    .WIDTH (PHASE_W),
    .DEPTH (MAX_TAPS)
  ) u_phase_ram (
    .clk_i   (clk_i),
    .we_i    (s1_vld_q),
    .waddr_i (s1_tap_q),
    .wdata_i (phase_next),
    .raddr_i (ctrl_i.tap),
    .rdata_o (ph_rdata)
  );

  // Stage 1: phase arrives; the advanced phase is written back at once.
  assign phase      = ph_vld_q[s1_tap_q] ? ph_rdata : '0;
  assign phase_next = phase + tap_cfg_i[s1_tap_q].step;

  // Stage 3: round depth times sine to whole samples and form the position.
  assign rnd     = {1'b0, s3_prod_q} + (MAG_W + 1)'(1 << (SINE_W - 1));
  assign off     = rnd[SINE_W +: DEPTH_W];
  assign off_w   = s3_neg_q ? HIST_AW'(-HIST_AW'(off)) : HIST_AW'(off);
  assign pos     = wp_i - tap_cfg_i[s3_tap_q].delay[HIST_AW-1:0] + off_w;
  assign pos_vld = hist_full_i || ((pos != '0) && (pos <= wp_i));

  assign hist_raddr_o = pos;

  // Stage 4: entries never written read as zero; weight by the gains.
  assign word = s4_hv_q ? hist_rdata_i : '0;
  assign hl_x = PROD_W'($signed(word[SAMPLE_W-1:0]));
  assign hr_x = PROD_W'($signed(word[HIST_W-1:SAMPLE_W]));
  assign gl_x = $signed(PROD_W'(tap_cfg_i[s4_tap_q].gain_l));
  assign gr_x = $signed(PROD_W'(tap_cfg_i[s4_tap_q].gain_r));

  // Control state of the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      ph_vld_q <= '0;
    end else begin
      s1_vld_q <= ctrl_i.issue;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      if (s1_vld_q) begin
        ph_vld_q[s1_tap_q] <= 1'b1;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    s1_tap_q  <= ctrl_i.tap;
    s2_tap_q  <= s1_tap_q;
    s3_tap_q  <= s2_tap_q;
    s4_tap_q  <= s3_tap_q;
    s2_mag_q  <= sine_mag(phase);
    s2_neg_q  <= phase[PHASE_W-1];
    s3_prod_q <= MAG_W'(tap_cfg_i[s2_tap_q].depth) * MAG_W'(s2_mag_q);
    s3_neg_q  <= s2_neg_q;
    s4_hv_q   <= pos_vld;
    s5_pl_q   <= hl_x * gl_x;
    s5_pr_q   <= hr_x * gr_x;
  end

  // Stage 5: exact Q8 sums over the taps of one request.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      acc_l_q <= '0;
      acc_r_q <= '0;
    end else if (s5_vld_q) begin
      acc_l_q <= acc_l_q + ACC_W'(s5_pl_q);
      acc_r_q <= acc_r_q + ACC_W'(s5_pr_q);
    end
  end

  assign stat_o.busy  = s1_vld_q | s2_vld_q | s3_vld_q | s4_vld_q | s5_vld_q;
  assign stat_o.acc_l = acc_l_q;
  assign stat_o.acc_r = acc_r_q;

endmodule

>>> rtl/multi_tap_chorus_unit.sv
// ============================================================================
// multi_tap_chorus_unit
// Stereo multi-tap chorus over a 64K-entry history memory.
// ============================================================================
//
//   Port    Role     Carries
//   in_i    sink     sample_left, sample_right (signed 16-bit)
//   out_o   source   out_left, out_right (signed 16-bit, saturated)
//   cfg_i   sink     idx (register number), data (62-bit write value)
//
// A request runs the number of active taps (tap_count, capped at four); the taps
// go one per cycle through the phase memory and then the history memory read port.
// Requests are handled one at a time; in_i.ready is high whenever the unit is idle,
// also while a result waits in the output register.
// A stalled output holds the finish step, and with it the history write.
// The history memory gets no clearing pass: a fill pointer and a wrapped
// flag mark which entries were written, and the rest read as zero.
//
module multi_tap_chorus_unit import cmt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  cmt_in_if.sink    in_i,
  cmt_out_if.source out_o,
  cmt_cfg_if.sink   cfg_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_q, state_d;
  logic [COUNT_W-1:0] iss_q, iss_d;
  logic [HIST_AW-1:0] wp_q, wp_d, wp_next;
  logic full_q, full_d;
  logic out_vld_q, out_vld_d;
  logic signed [SAMPLE_W-1:0] out_l_q, out_r_q;
  logic signed [SAMPLE_W-1:0] smp_l_q, smp_r_q;

  logic [COUNT_W-1:0] active;
  tap_cfg_t           tap_cfg [MAX_TAPS];
  tap_ctrl_t          tap_ctrl;
  tap_stat_t          tap_stat;
  logic [HIST_AW-1:0] hist_raddr;
  logic [HIST_W-1:0]  hist_rdata;
  logic               in_acc;
  logic               done;
  logic               finish;

  // Saturating Q8-to-integer conversion with round half up.
  function automatic logic signed [SAMPLE_W-1:0] to_sample(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] sh;
    rnd = acc + ACC_W'(128);
    sh  = rnd >>> 8;
    if (sh > ACC_W'(32767)) begin
      return SAMPLE_W'(32767);
    end else if (sh < -ACC_W'(32768)) begin
      return SAMPLE_W'(-32768);
    end else begin
      return sh[SAMPLE_W-1:0];
    end
  endfunction

  cmt_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .active_o  (active),
    .tap_cfg_o (tap_cfg)
  );

  cmt_tap_path u_tap_path (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (tap_ctrl),
    .tap_cfg_i    (tap_cfg),
    .wp_i         (wp_q),
    .hist_full_i  (full_q),
    .hist_raddr_o (hist_raddr),
    .hist_rdata_i (hist_rdata),
    .stat_o       (tap_stat)
  );

  cmt_ram #(
    .WIDTH (HIST_W),
    .DEPTH (HISTORY_LEN)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (finish),
    .waddr_i (wp_next),
    .wdata_i ({smp_r_q, smp_l_q}),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  // Handshakes and tap issue.
  assign in_i.ready     = (state_q == ST_IDLE);
  assign in_acc         = in_i.valid && in_i.ready;
  assign tap_ctrl.clear = in_acc;
  assign tap_ctrl.issue = (state_q == ST_RUN) && (iss_q < active);
  assign tap_ctrl.tap   = iss_q[TAP_W-1:0];
  assign done           = !tap_ctrl.issue && !tap_stat.busy;
  assign finish         = (state_q == ST_RUN) && done && (!out_vld_q || out_o.ready);
  assign wp_next        = wp_q + HIST_AW'(1);

  // Sequencer next state.
  always_comb begin
    state_d   = state_q;
    iss_d     = iss_q;
    wp_d      = wp_q;
    full_d    = full_q;
    out_vld_d = out_vld_q && !out_o.ready;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_RUN;
          iss_d   = '0;
        end
      end
      ST_RUN: begin
        if (tap_ctrl.issue) begin
          iss_d = iss_q + COUNT_W'(1);
        end
        if (finish) begin
          state_d   = ST_IDLE;
          wp_d      = wp_next;
          full_d    = full_q || (wp_next == '0);
          out_vld_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      iss_q     <= '0;
      wp_q      <= '0;
      full_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      iss_q     <= iss_d;
      wp_q      <= wp_d;
      full_q    <= full_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Sample capture and result register.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smp_l_q <= in_i.sample_left;
      smp_r_q <= in_i.sample_right;
    end
    if (finish) begin
      out_l_q <= to_sample(tap_stat.acc_l);
      out_r_q <= to_sample(tap_stat.acc_r);
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.out_left  = out_l_q;
  assign out_o.out_right = out_r_q;

  // The tap pipeline is empty whenever a new request can be taken.
  a_idle_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !tap_stat.busy)
    else $error("tap pipeline busy while idle");

  // Every history write comes with a result in the output register.
  a_write_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_o.valid)
    else $error("history written without a result");

  // A new request starts from cleared sums.
  a_acc_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (tap_stat.acc_l == '0) && (tap_stat.acc_r == '0))
    else $error("sums not cleared at request start");

endmodule
